// ----- hdl/plsa_pkg.sv -----
// ----------------------------------------------------------------------------
// plsa_pkg
// Shared types and constants of the positional list shift array: sizes,
// opcode and status codes, and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package plsa_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_BITS  = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_BITS   = 7;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 7;
  localparam int WIDE_BITS  = 64;
  localparam int CMP_W      = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } plsa_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } plsa_status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } plsa_act_e;

  typedef logic [ITEM_BITS-1:0] item_t;

  typedef struct packed {
    plsa_act_e        act;
    logic [IDX_W-1:0] idx;
    item_t            data;
  } plsa_cmd_t;

endpackage

// ----- hdl/plsa_cell.sv -----
// ----------------------------------------------------------------------------
// plsa_cell
// One list slot: holds an entry, loads new data, or takes the entry of its
// left or right neighbor depending on the broadcast command.
// ----------------------------------------------------------------------------
module plsa_cell (
  input  logic                       clk_i,
  input  plsa_pkg::plsa_cmd_t        cmd_i,
  input  logic [plsa_pkg::IDX_W-1:0] cell_idx_i,
  input  plsa_pkg::item_t            left_i,
  input  plsa_pkg::item_t            right_i,
  output plsa_pkg::item_t            entry_o,
  output plsa_pkg::item_t            tap_o
);
  import plsa_pkg::*;

  item_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.act)
      ACT_APPEND: begin
        if (cell_idx_i == cmd_i.idx) entry_d = cmd_i.data;
      end
      ACT_INSERT: begin
        if (cell_idx_i == cmd_i.idx) begin
          entry_d = cmd_i.data;
        end else if (cell_idx_i > cmd_i.idx) begin
          entry_d = left_i;
        end
      end
      ACT_REMOVE: begin
        if (cell_idx_i >= cmd_i.idx) entry_d = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // read bus: only the addressed cell drives nonzero
  assign tap_o   = (cell_idx_i == cmd_i.idx) ? entry_q : '0;

endmodule

// ----- hdl/plsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// plsa_ctrl
// Request decode, bounds/empty/full checks, entry count and the result
// registers. Drives the command that the cell row executes.
// ----------------------------------------------------------------------------
module plsa_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [1:0]                      opcode_i,
  input  logic [plsa_pkg::POS_BITS-1:0]   position_i,
  input  logic [plsa_pkg::VALUE_BITS-1:0] value_i,
  input  plsa_pkg::item_t                 rd_data_i,
  output plsa_pkg::plsa_cmd_t             cmd_o,
  output logic                            result_valid_o,
  output logic [plsa_pkg::VALUE_BITS-1:0] read_value_o,
  output logic [1:0]                      status_o,
  output logic [plsa_pkg::COUNT_BITS-1:0] item_count_o
);
  import plsa_pkg::*;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  valid_q;
  logic [VALUE_BITS-1:0] rd_q;
  plsa_status_e          st_q;
  logic [COUNT_BITS-1:0] cnt_out_q;

  plsa_op_e              op;
  plsa_status_e          st;
  logic [CMP_W-1:0]      pos_w, cnt_w, cnt_next_w;
  logic [WIDE_BITS-1:0]  val_wide, rd_wide;
  logic                  full, empty;

  always_comb begin
    op         = plsa_op_e'(opcode_i);
    pos_w      = CMP_W'(position_i);
    cnt_w      = CMP_W'(count_q);
    full       = (count_q == CNT_W'(DEPTH));
    empty      = (count_q == '0);
    val_wide   = WIDE_BITS'(value_i);
    rd_wide    = '0;
    st         = ST_OK;
    count_d    = count_q;
    cmd_o.act  = ACT_HOLD;
    cmd_o.idx  = pos_w[IDX_W-1:0];
    cmd_o.data = val_wide[ITEM_BITS-1:0];
    case (op)
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd_o.act = ACT_APPEND;
          cmd_o.idx = count_q[IDX_W-1:0];
          count_d   = CNT_W'(count_q + 1'b1);
        end
      end
      OP_INSERT: begin
        // position check takes priority over full
        if (pos_w > cnt_w) begin
          st = ST_BOUNDS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd_o.act = ACT_INSERT;
          count_d   = CNT_W'(count_q + 1'b1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          st = ST_BOUNDS;
        end else begin
          cmd_o.act = ACT_REMOVE;
          count_d   = CNT_W'(count_q - 1'b1);
        end
      end
      OP_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          st = ST_BOUNDS;
        end else begin
          rd_wide = WIDE_BITS'(rd_data_i);
        end
      end
      default: ;
    endcase
    if (!accept_i) begin
      cmd_o.act = ACT_HOLD;
      count_d   = count_q;
    end
    cnt_next_w = CMP_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q      <= rd_wide[VALUE_BITS-1:0];
      st_q      <= st;
      cnt_out_q <= cnt_next_w[COUNT_BITS-1:0];
    end
  end

  assign result_valid_o = valid_q;
  assign read_value_o   = rd_q;
  assign status_o       = st_q;
  assign item_count_o   = cnt_out_q;

endmodule

// ----- hdl/positional_list_shift_array.sv -----
// A result strobes in the cycle after its request transfer.
// Throughput: one request per cycle; busy stays low, since every cell takes
// its neighbor's entry in the same cycle, so a full shift needs no extra state.
// Reset clears the entry count and the result strobe; entry contents are
// not cleared and only entries below the count are ever read.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// positional_list_shift_array
// Fixed-capacity list addressed by position, built as a row of shift cells
// with append, insert-at, remove-at and read-at requests.
// ----------------------------------------------------------------------------
module positional_list_shift_array (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode_i,
  input  logic [plsa_pkg::POS_BITS-1:0]   position_i,
  input  logic [plsa_pkg::VALUE_BITS-1:0] value_i,
  output logic                            result_valid_o,
  output logic [plsa_pkg::VALUE_BITS-1:0] read_value_o,
  output logic [1:0]                      status_o,
  output logic [plsa_pkg::COUNT_BITS-1:0] item_count_o
);
  import plsa_pkg::*;

  plsa_cmd_t cmd;
  item_t     entry [DEPTH];
  item_t     tap   [DEPTH];
  item_t     rd_bus;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  plsa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .rd_data_i      (rd_bus),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    item_t left_w, right_w;
    // end cells see their own entry where no neighbor exists
    if (i == 0) begin : g_first
      assign left_w = entry[i];
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry[i];
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end

    plsa_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (IDX_W'(i)),
      .left_i     (left_w),
      .right_i    (right_w),
      .entry_o    (entry[i]),
      .tap_o      (tap[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | tap[k];
    end
  end

endmodule

// ----- hdl/plsa_checker.sv -----
// ----------------------------------------------------------------------------
// plsa_checker
// Port-level checks on the positional list: result timing, count range and
// consistency of status against read data.
// ----------------------------------------------------------------------------
module plsa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [1:0]                      opcode_i,
  input logic [plsa_pkg::POS_BITS-1:0]   position_i,
  input logic [plsa_pkg::VALUE_BITS-1:0] value_i,
  input logic                            result_valid_o,
  input logic [plsa_pkg::VALUE_BITS-1:0] read_value_o,
  input logic [1:0]                      status_o,
  input logic [plsa_pkg::COUNT_BITS-1:0] item_count_o
);
  import plsa_pkg::*;

  logic [CMP_W-1:0] cnt_w;
  assign cnt_w = CMP_W'(item_count_o);

  // every transfer yields exactly one result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("missing result after request transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without request transfer");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_EMPTY) |-> item_count_o == '0)
    else $error("empty status with nonzero count");

  // nonzero read data only from a successful read
  a_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && read_value_o != '0) |->
      (status_o == ST_OK && $past(opcode_i) == OP_READ))
    else $error("read data on a non-read or failed request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && DEPTH < (1 << COUNT_BITS)) |-> cnt_w <= CMP_W'(DEPTH))
    else $error("item count above capacity");

endmodule

bind positional_list_shift_array plsa_checker u_plsa_checker (.*);

// ----- sim/positional_list_shift_array_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_shift_array_checker
// Watches the request and result channels of the positional list, keeps its
// own copy of the list, predicts the answer to every request transfer and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_list_shift_array_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_start_i,
  input  logic                            req_busy_i,
  input  logic [1:0]                      req_opcode_i,
  input  logic [plsa_pkg::POS_BITS-1:0]   req_position_i,
  input  logic [plsa_pkg::VALUE_BITS-1:0] req_value_i,
  input  logic                            rsp_valid_i,
  input  logic [plsa_pkg::VALUE_BITS-1:0] rsp_read_value_i,
  input  logic [1:0]                      rsp_status_i,
  input  logic [plsa_pkg::COUNT_BITS-1:0] rsp_item_count_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import plsa_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    plsa_status_e          status;
    logic [COUNT_BITS-1:0] item_count;
  } list_answer_t;

  item_t        shadow_list [DEPTH];
  int           shadow_count;
  list_answer_t answer_q [$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    shadow_count     = 0;
  end

  task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] want,
                                 logic [VALUE_BITS-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_count_o++;
  endtask

  // applies one request to the shadow list and returns the answer it gives
  function automatic list_answer_t apply_request(plsa_op_e op, int pos, item_t val);
    list_answer_t ans;
    int           i;
    ans.read_value = '0;
    ans.status     = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_INSERT: begin
        // bounds is checked ahead of full
        if (pos > shadow_count) begin
          ans.status = ST_BOUNDS;
        end else if (shadow_count >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          ans.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          ans.status = ST_BOUNDS;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          ans.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          ans.status = ST_BOUNDS;
        end else begin
          ans.read_value = shadow_list[pos];
        end
      end
    endcase
    ans.item_count = COUNT_BITS'(shadow_count);
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_answer_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      answer_q.delete();
      pending_o <= 0;
    end else begin
      // a result always belongs to a transfer from an earlier edge
      if (rsp_valid_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unrequested result read_value", '0, rsp_read_value_i);
        end else begin
          want = answer_q.pop_front();
          if (rsp_read_value_i !== want.read_value)
            report_mismatch("read_value", want.read_value, rsp_read_value_i);
          if (rsp_status_i !== want.status)
            report_mismatch("status", want.status, rsp_status_i);
          if (rsp_item_count_i !== want.item_count)
            report_mismatch("item_count", want.item_count, rsp_item_count_i);
        end
      end
      if (req_start_i === 1'b1 && req_busy_i === 1'b0) begin
        answer_q.push_back(apply_request(plsa_op_e'(req_opcode_i), int'(req_position_i),
                                         item_t'(req_value_i)));
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

// ----- sim/positional_list_shift_array_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_shift_array_tb
// Drives append, insert, remove and read requests into the positional list:
// a directed pass over empty, tail and out-of-range cases, then random
// traffic that swings the list between empty and full. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module positional_list_shift_array_tb;
  import plsa_pkg::*;

  localparam int RANDOM_ITEMS = 750;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } traffic_mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            opcode_i;
  logic [POS_BITS-1:0]   position_i;
  logic [VALUE_BITS-1:0] value_i;
  logic                  result_valid_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic [1:0]            status_o;
  logic [COUNT_BITS-1:0] item_count_o;
  int                    mismatch_count;
  int                    pending;
  int                    occupancy;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  positional_list_shift_array u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o)
  );

  positional_list_shift_array_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_start_i      (start),
    .req_busy_i       (busy),
    .req_opcode_i     (opcode_i),
    .req_position_i   (position_i),
    .req_value_i      (value_i),
    .rsp_valid_i      (result_valid_o),
    .rsp_read_value_i (read_value_o),
    .rsp_status_i     (status_o),
    .rsp_item_count_i (item_count_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // holds the request until it transfers, then tracks the fill level
  task automatic issue_request(plsa_op_e op, int pos, logic [VALUE_BITS-1:0] val);
    start      <= 1'b1;
    opcode_i   <= op;
    position_i <= POS_BITS'(pos);
    value_i    <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    case (op)
      OP_APPEND: if (occupancy < DEPTH) occupancy++;
      OP_INSERT: if (pos <= occupancy && occupancy < DEPTH) occupancy++;
      OP_REMOVE: if (occupancy > 0 && pos < occupancy) occupancy--;
      default: ;
    endcase
  endtask

  task automatic pause_requests(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic plsa_op_e pick_op(traffic_mix_e mix);
    int roll;
    roll = $urandom_range(0, 9);
    case (mix)
      MIX_GROW:   return roll < 4 ? OP_APPEND : roll < 7 ? OP_INSERT :
                         roll < 8 ? OP_REMOVE : OP_READ;
      MIX_SHRINK: return roll < 1 ? OP_APPEND : roll < 2 ? OP_INSERT :
                         roll < 7 ? OP_REMOVE : OP_READ;
      default:    return plsa_op_e'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly legal positions, with the tail, the head and the whole field mixed in
  function automatic int pick_position(plsa_op_e op);
    int roll;
    int upper;
    roll  = $urandom_range(0, 19);
    upper = (op == OP_INSERT) ? occupancy : occupancy - 1;
    if (roll < 2) return $urandom_range(0, 127);
    if (roll < 4) return occupancy;
    if (roll < 5 || upper < 0) return 0;
    return $urandom_range(0, upper);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    traffic_mix_e mix;
    plsa_op_e     op;
    int           sent;
    int           seg_left;
    int           burst_left;
    start      <= 1'b0;
    opcode_i   <= OP_APPEND;
    position_i <= '0;
    value_i    <= '0;
    rst_ni     <= 1'b0;
    occupancy  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, out-of-range inserts, head and tail inserts, reads and removes
    issue_request(OP_READ,     0, 32'h0000_0000);
    issue_request(OP_REMOVE,   0, 32'h0000_0000);
    issue_request(OP_INSERT,   1, 32'h1111_1111);
    issue_request(OP_INSERT, 127, 32'h2222_2222);
    issue_request(OP_REMOVE, 127, 32'h0000_0000);
    issue_request(OP_INSERT,   0, 32'hFFFF_FFFF);
    issue_request(OP_APPEND, 127, 32'h0000_0000);
    issue_request(OP_INSERT,   2, 32'hA5A5_A5A5);
    issue_request(OP_INSERT,   1, 32'h5A5A_5A5A);
    issue_request(OP_READ,     0, 32'h0000_0000);
    issue_request(OP_READ,     3, 32'h0000_0000);
    issue_request(OP_READ,     4, 32'h0000_0000);
    issue_request(OP_READ,   127, 32'hFFFF_FFFF);
    issue_request(OP_REMOVE,   4, 32'h0000_0000);
    issue_request(OP_REMOVE,   1, 32'h0000_0000);
    issue_request(OP_REMOVE,   2, 32'h0000_0000);
    issue_request(OP_INSERT,   3, 32'h3333_3333);
    issue_request(OP_READ,     1, 32'h0000_0000);
    issue_request(OP_REMOVE,   0, 32'h0000_0000);
    issue_request(OP_REMOVE,   0, 32'h0000_0000);
    issue_request(OP_APPEND,   0, 32'h1234_5678);
    issue_request(OP_READ,    64, 32'h0000_0000);
    drain_results();

    // segments lean toward growth or shrinkage so the list hits full and empty
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix      = traffic_mix_e'($urandom_range(0, 2));
      seg_left = $urandom_range(30, 120);
      if ($urandom_range(0, 3) == 0) drain_results();
      while (seg_left > 0 && sent < RANDOM_ITEMS) begin
        burst_left = $urandom_range(1, 40);
        while (burst_left > 0 && seg_left > 0 && sent < RANDOM_ITEMS) begin
          op = pick_op(mix);
          issue_request(op, pick_position(op), pick_value());
          burst_left--;
          seg_left--;
          sent++;
        end
        pause_requests($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/plsa_pkg.sv
hdl/plsa_cell.sv
hdl/plsa_ctrl.sv
hdl/positional_list_shift_array.sv
hdl/plsa_checker.sv
sim/positional_list_shift_array_checker.sv
sim/positional_list_shift_array_tb.sv
